// ----- src/pds_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pds_pkg;

  localparam int unsigned OSC_W  = 26;
  localparam int unsigned MAX_W  = 30;
  localparam int unsigned SRC_W  = 5;
  localparam int unsigned REF_W  = 25;
  localparam int unsigned DVD_W  = 34;
  localparam int unsigned STEP_W = 4;
  localparam int unsigned CFG_W  = 30;

  localparam logic [31:0] MIN_TARGET  = 32'd10000000;
  localparam logic [31:0] CCO_MIN     = 32'd156000000;
  localparam logic [2:0]  MAX_DOUBLES = 3'd4;
  localparam logic [DVD_W-1:0] MULT_MAX = DVD_W'(256);
  localparam logic [1:0]  REF_DIV_SEL = 2'd2;

  // ceil(2^27 / 3): exact quotient by 3 for any 26-bit oscillator value.
  localparam logic [OSC_W-1:0] RECIP3       = 26'd44739243;
  localparam int unsigned      RECIP3_SHIFT = 27;

  typedef enum logic [1:0] {
    CFG_OSC_RATE     = 2'd0,
    CFG_MAX_OUT_FREQ = 2'd1,
    CFG_CLOCK_SOURCE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] req_freq;
    logic [31:0] old_ctrl;
  } in_item_t;

  typedef struct packed {
    logic [31:0] ctrl_word;
    logic        ctrl_valid;
    logic [31:0] out_freq;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_REF,
    OP_DOUBLE,
    OP_DIV_MULT,
    OP_SAVE_MULT,
    OP_DIV_LIMIT,
    OP_CLAMP,
    OP_SAT,
    OP_PROD,
    OP_EMIT,
    OP_FAIL
  } op_t;

  typedef enum logic [1:0] {
    W_NONE,
    W_IN,
    W_DIV,
    W_OUT
  } wait_t;

  typedef enum logic [2:0] {
    J_NEVER,
    J_ALWAYS,
    J_REF_ZERO,
    J_MULT_ZERO,
    J_DOUBLE
  } jump_t;

  typedef struct packed {
    op_t               op;
    wait_t             wt;
    jump_t             jc;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic out_blocked;
    logic div_busy;
    logic ref_zero;
    logic mult_zero;
    logic can_double;
  } status_t;

  localparam logic [STEP_W-1:0] S_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] S_DOUBLE = 4'd2;
  localparam logic [STEP_W-1:0] S_FAIL   = 4'd13;

  function automatic ucode_t uc(input op_t op, input wait_t wt, input jump_t jc,
                                input logic [STEP_W-1:0] tgt);
    ucode_t w;
    w.op     = op;
    w.wt     = wt;
    w.jc     = jc;
    w.target = tgt;
    return w;
  endfunction

  // Control store. A step holds while its wait condition is true, then jumps
  // to its target if the jump condition is true, else falls through.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    case (step)
      4'd0:    w = uc(OP_LOAD,      W_IN,   J_NEVER,     S_IDLE);
      4'd1:    w = uc(OP_REF,       W_NONE, J_NEVER,     S_IDLE);
      4'd2:    w = uc(OP_DOUBLE,    W_NONE, J_DOUBLE,    S_DOUBLE);
      4'd3:    w = uc(OP_NOP,       W_NONE, J_REF_ZERO,  S_FAIL);
      4'd4:    w = uc(OP_DIV_MULT,  W_NONE, J_NEVER,     S_IDLE);
      4'd5:    w = uc(OP_NOP,       W_DIV,  J_NEVER,     S_IDLE);
      4'd6:    w = uc(OP_SAVE_MULT, W_NONE, J_NEVER,     S_IDLE);
      4'd7:    w = uc(OP_DIV_LIMIT, W_NONE, J_NEVER,     S_IDLE);
      4'd8:    w = uc(OP_NOP,       W_DIV,  J_NEVER,     S_IDLE);
      4'd9:    w = uc(OP_CLAMP,     W_NONE, J_NEVER,     S_IDLE);
      4'd10:   w = uc(OP_SAT,       W_NONE, J_MULT_ZERO, S_FAIL);
      4'd11:   w = uc(OP_PROD,      W_NONE, J_NEVER,     S_IDLE);
      4'd12:   w = uc(OP_EMIT,      W_OUT,  J_ALWAYS,    S_IDLE);
      4'd13:   w = uc(OP_FAIL,      W_OUT,  J_ALWAYS,    S_IDLE);
      default: w = uc(OP_NOP,       W_NONE, J_ALWAYS,    S_IDLE);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- src/pds_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface pds_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- src/pds_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pds_divider (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [pds_pkg::DVD_W-1:0]  dividend,
  input  wire logic [pds_pkg::REF_W-1:0]  divisor,
  output logic                            busy,
  output logic [pds_pkg::DVD_W-1:0]       quotient
);
  import pds_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [REF_W-1:0] rem_r;
  logic [REF_W-1:0] dvs_r;
  logic [DVD_W-1:0] quo_r;

  logic [REF_W:0]   trial;
  logic [REF_W:0]   diff;
  logic             fits;
  logic [REF_W-1:0] rem_nxt;

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // of quo_r at the top while quotient bits enter at the bottom.
  always_comb begin
    trial   = {rem_r, quo_r[DVD_W-1]};
    diff    = trial - {1'b0, dvs_r};
    fits    = (trial >= {1'b0, dvs_r});
    rem_nxt = fits ? diff[REF_W-1:0] : trial[REF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DVD_W - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

`ifndef ASSERT_OFF
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider did not go busy after start");

  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start && cnt_r == '0) |=> !busy_r)
    else $error("divider ran past its last quotient bit");
`endif

endmodule

`default_nettype wire

// ----- src/pds_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pds_sequencer (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pds_pkg::status_t st,
  output pds_pkg::ucode_t       cw,
  output logic                  go
);
  import pds_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic              stall;
  logic              take_jump;

  assign cw = ucode_rom(step_r);

  always_comb begin
    case (cw.wt)
      W_IN:    stall = !st.in_valid;
      W_DIV:   stall = st.div_busy;
      W_OUT:   stall = st.out_blocked;
      default: stall = 1'b0;
    endcase
  end

  always_comb begin
    case (cw.jc)
      J_ALWAYS:    take_jump = 1'b1;
      J_REF_ZERO:  take_jump = st.ref_zero;
      J_MULT_ZERO: take_jump = st.mult_zero;
      J_DOUBLE:    take_jump = st.can_double;
      default:     take_jump = 1'b0;
    endcase
  end

  always_comb begin
    if (stall) begin
      step_nxt = step_r;
    end else if (take_jump) begin
      step_nxt = cw.target;
    end else begin
      step_nxt = step_r + 1'b1;
    end
  end

  assign go = !stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= S_FAIL)
    else $error("step counter left the program");
`endif

endmodule

`default_nettype wire

// ----- src/pds_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pds_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  pds_stream_if.sink                     in_ch,
  pds_stream_if.source                   out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [pds_pkg::CFG_W-1:0] cfg_data,
  input  wire pds_pkg::ucode_t           cw,
  input  wire logic                      go,
  output pds_pkg::status_t               st
);
  import pds_pkg::*;

  logic [OSC_W-1:0] osc_r;
  logic [MAX_W-1:0] max_r;
  logic [SRC_W-1:0] src_r;

  logic [31:0]      cco_r;
  logic [31:0]      old_r;
  logic [2:0]       doubles_r;
  logic [REF_W-1:0] ref_r;
  logic [DVD_W-1:0] mult_r;
  logic [DVD_W-1:0] prod_r;
  out_item_t        out_r;
  logic             out_valid_r;

  logic                   can_double;
  logic [2*OSC_W-1:0]     ref_prod;
  logic [DVD_W:0]         lim_full;
  logic [DVD_W-1:0]       dividend;
  logic                   div_start;
  logic                   div_busy;
  logic [DVD_W-1:0]       quotient;
  logic [31:0]            word;
  logic [1:0]             psel;
  logic                   direct;
  logic [31:0]            target_in;
  logic                   emit_go;
  logic                   fail_go;

  assign target_in  = in_ch.payload.req_freq;
  assign can_double = (cco_r < CCO_MIN) && (doubles_r < MAX_DOUBLES);
  assign ref_prod   = osc_r * RECIP3;

  // Largest multiplier bound: ((max + 1) * post_divide - 1) / ref.
  assign lim_full = ((DVD_W+1)'(max_r) + 1'b1 << doubles_r) - 1'b1;

  always_comb begin
    if (cw.op == OP_DIV_LIMIT) begin
      dividend = lim_full[DVD_W-1:0];
    end else begin
      dividend = DVD_W'(cco_r) + DVD_W'(ref_r) - 1'b1;
    end
  end

  assign div_start = go && (cw.op == OP_DIV_MULT || cw.op == OP_DIV_LIMIT);

  pds_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (ref_r),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign direct = (doubles_r == 3'd0);
  assign psel   = direct ? 2'd0 : 2'(doubles_r - 3'd1);

  always_comb begin
    word          = old_r;
    word[28:24]   = src_r;
    word[1]       = 1'b0;
    word[6]       = 1'b0;
    word[7]       = direct;
    word[9:8]     = psel;
    word[13:12]   = REF_DIV_SEL;
    word[23:16]   = mult_r[7:0] - 8'd1;
    word[0]       = 1'b0;
  end

  assign emit_go = go && (cw.op == OP_EMIT);
  assign fail_go = go && (cw.op == OP_FAIL);

  assign in_ch.ready    = (cw.op == OP_LOAD);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

  always_comb begin
    st.in_valid    = in_ch.valid;
    st.out_blocked = out_valid_r && !out_ch.ready;
    st.div_busy    = div_busy;
    st.ref_zero    = (ref_r == '0);
    st.mult_zero   = (mult_r == '0);
    st.can_double  = can_double;
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      osc_r       <= OSC_W'(12000000);
      max_r       <= MAX_W'(204000000);
      src_r       <= SRC_W'(6);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OSC_RATE:     osc_r <= cfg_data[OSC_W-1:0];
          CFG_MAX_OUT_FREQ: max_r <= cfg_data[MAX_W-1:0];
          CFG_CLOCK_SOURCE: src_r <= cfg_data[SRC_W-1:0];
          default:          ;
        endcase
      end
      if (emit_go || fail_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers of the datapath, one operation per step.
  always_ff @(posedge clk) begin
    if (go) begin
      case (cw.op)
        OP_LOAD: begin
          if (in_ch.valid) begin
            cco_r     <= (target_in < MIN_TARGET) ? MIN_TARGET : target_in;
            old_r     <= in_ch.payload.old_ctrl;
            doubles_r <= 3'd0;
          end
        end
        OP_REF: begin
          ref_r <= ref_prod[RECIP3_SHIFT +: REF_W];
        end
        OP_DOUBLE: begin
          if (can_double) begin
            cco_r     <= {cco_r[30:0], 1'b0};
            doubles_r <= doubles_r + 3'd1;
          end
        end
        OP_SAVE_MULT: begin
          mult_r <= quotient;
        end
        OP_CLAMP: begin
          if (quotient < mult_r) begin
            mult_r <= quotient;
          end
        end
        OP_SAT: begin
          if (mult_r > MULT_MAX) begin
            mult_r <= MULT_MAX;
          end
        end
        OP_PROD: begin
          prod_r <= DVD_W'(ref_r) * DVD_W'(mult_r[8:0]);
        end
        OP_EMIT: begin
          out_r.ctrl_word  <= word;
          out_r.ctrl_valid <= 1'b1;
          out_r.out_freq   <= 32'(prod_r >> doubles_r);
        end
        OP_FAIL: begin
          out_r.ctrl_word  <= '0;
          out_r.ctrl_valid <= 1'b0;
          out_r.out_freq   <= '0;
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.ctrl_valid) |-> (out_r.ctrl_word == '0 && out_r.out_freq == '0))
    else $error("failure transaction carries nonzero fields");

  a_word_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.ctrl_valid) |->
      (out_r.ctrl_word[13:12] == REF_DIV_SEL && out_r.ctrl_word[0] == 1'b0))
    else $error("control word fixed fields are wrong");
`endif

endmodule

`default_nettype wire

// ----- src/pll_divider_search_top.sv -----
// Channel  Direction  Payload                                Transfer
// in_ch    sink       req_freq[31:0], old_ctrl[31:0]          valid && ready
// out_ch   source     ctrl_word[31:0], ctrl_valid, out_freq   valid && ready
// cfg_*    write      cfg_index[1:0], cfg_data[29:0]          cfg_we
//
// A transaction holds the program until it is finished, and the next one is not
// accepted before then: two divisions by the reference share one restoring
// divider, and the doubling step repeats while doubling is still allowed.
// A request whose reference is zero skips both divisions and fails early.
// Reset is synchronous and active low; it restarts the program and restores
// the register defaults. A finished result waits in the output register while
// the next one is accepted; a full output holds only the emit or fail step.
`timescale 1ns / 1ps
`default_nettype none

module pll_divider_search_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  pds_stream_if.sink                     in_ch,
  pds_stream_if.source                   out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [pds_pkg::CFG_W-1:0] cfg_data
);
  import pds_pkg::*;

  ucode_t  cw;
  logic    go;
  status_t st;

  pds_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cw    (cw),
    .go    (go)
  );

  pds_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cw        (cw),
    .go        (go),
    .st        (st)
  );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

class pll_word_checker;
  localparam logic [63:0] REF_DIV = 64'd3;

  logic [25:0] osc_rate;
  logic [29:0] max_out_freq;
  logic [4:0]  clock_source;
  pds_pkg::out_item_t pending_words[$];
  int errors;

  function new();
    osc_rate     = 26'd12000000;
    max_out_freq = 30'd204000000;
    clock_source = 5'd6;
    errors       = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [pds_pkg::CFG_W-1:0] data);
    case (idx)
      pds_pkg::CFG_OSC_RATE:     osc_rate     = data[25:0];
      pds_pkg::CFG_MAX_OUT_FREQ: max_out_freq = data[29:0];
      pds_pkg::CFG_CLOCK_SOURCE: clock_source = data[4:0];
      default: ;
    endcase
  endfunction

  function pds_pkg::out_item_t predict_ctrl_word(pds_pkg::in_item_t req);
    pds_pkg::out_item_t res;
    logic [63:0] cco, pdiv, ref_freq, mult, mult_limit, freq;
    logic [31:0] word;
    int doubles;
    res = '0;
    cco = 64'(req.req_freq);
    if (cco < 64'(pds_pkg::MIN_TARGET)) cco = 64'(pds_pkg::MIN_TARGET);
    pdiv = 64'd1;
    doubles = 0;
    while (cco < 64'(pds_pkg::CCO_MIN) && doubles < int'(pds_pkg::MAX_DOUBLES)) begin
      cco = cco * 2;
      pdiv = pdiv * 2;
      doubles++;
    end
    ref_freq = 64'(osc_rate) / REF_DIV;
    if (ref_freq == 0) return res;
    mult = (cco + ref_freq - 1) / ref_freq;
    // Largest multiplier that keeps the divided output within the limit.
    mult_limit = ((64'(max_out_freq) + 1) * pdiv - 1) / ref_freq;
    if (mult > mult_limit) mult = mult_limit;
    if (mult == 0) return res;
    if (mult > 64'(pds_pkg::MULT_MAX)) mult = 64'(pds_pkg::MULT_MAX);
    freq = (ref_freq * mult) / pdiv;
    word = req.old_ctrl;
    word[28:24] = clock_source;
    word[1] = 1'b0;
    word[6] = 1'b0;
    word[7] = (doubles == 0);
    word[9:8] = (doubles == 0) ? 2'd0 : 2'(doubles - 1);
    word[13:12] = pds_pkg::REF_DIV_SEL;
    word[23:16] = 8'(mult - 1);
    word[0] = 1'b0;
    res.ctrl_word  = word;
    res.ctrl_valid = 1'b1;
    res.out_freq   = freq[31:0];
    return res;
  endfunction

  function void note_request(pds_pkg::in_item_t req);
    pending_words.push_back(predict_ctrl_word(req));
  endfunction

  function void check_result(pds_pkg::out_item_t got);
    pds_pkg::out_item_t exp;
    if (pending_words.size() == 0) begin
      $display("%0t: unexpected result word=%h valid=%b freq=%0d",
               $time, got.ctrl_word, got.ctrl_valid, got.out_freq);
      errors++;
      return;
    end
    exp = pending_words.pop_front();
    if (got.ctrl_word !== exp.ctrl_word) begin
      $display("%0t: ctrl_word expected %h actual %h", $time, exp.ctrl_word, got.ctrl_word);
      errors++;
    end
    if (got.ctrl_valid !== exp.ctrl_valid) begin
      $display("%0t: ctrl_valid expected %b actual %b", $time, exp.ctrl_valid,
               got.ctrl_valid);
      errors++;
    end
    if (got.out_freq !== exp.out_freq) begin
      $display("%0t: out_freq expected %0d actual %0d", $time, exp.out_freq, got.out_freq);
      errors++;
    end
  endfunction
endclass

module testbench;
  import pds_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 210;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  int sender_idle_pct;
  int receiver_stall_pct;

  pll_word_checker board;

  pds_stream_if #(.payload_t(in_item_t))  in_if ();
  pds_stream_if #(.payload_t(out_item_t)) out_if ();

  pll_divider_search_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if.sink),
    .out_ch   (out_if.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("== FAIL ==");
    $finish;
  end

  always @(negedge clk) begin
    out_if.ready = ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) board.note_request(in_if.payload);
      if (out_if.valid && out_if.ready) board.check_result(out_if.payload);
    end
  end

  // Entered and left at a falling edge; valid stays high for the next call.
  task automatic send_request(logic [31:0] target, logic [31:0] old_ctrl);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.payload.req_freq = target;
    in_if.payload.old_ctrl = old_ctrl;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_if.valid = 1'b0;
    while (board.pending_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      1:       begin sender_idle_pct = 81; receiver_stall_pct = 0;  end
      2:       begin sender_idle_pct = 0;  receiver_stall_pct = 81; end
      3:       begin sender_idle_pct = 35; receiver_stall_pct = 35; end
      default: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
    endcase
  endtask

  initial begin
    logic [31:0] target;
    logic [25:0] osc;
    logic [29:0] max_f;
    logic [4:0] src;
    logic [CFG_W-1:0] noise;
    board = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    out_if.ready = 1'b0;
    set_idling(0);
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part at the reset settings: band edges and control word extremes.
    send_request(32'd0, 32'h0000_0000);
    send_request(32'd9999999, 32'hFFFF_FFFF);
    send_request(32'd10000000, 32'hA5A5_5A5A);
    send_request(32'd78000000, 32'hFFFF_FFFF);
    send_request(32'd155999999, 32'h0000_0000);
    send_request(32'd156000000, 32'hFFFF_FFFF);
    send_request(32'd204000000, 32'h1234_5678);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain_results();

    // A reference below one hertz fails before any division.
    write_reg(CFG_OSC_RATE, 30'd0);
    send_request(32'd100000000, 32'hFFFF_FFFF);
    drain_results();
    write_reg(CFG_OSC_RATE, 30'd2);
    send_request(32'd200000000, 32'h0F0F_0F0F);
    drain_results();

    // A one hertz reference drives the multiplier into saturation.
    write_reg(CFG_OSC_RATE, 30'd3);
    write_reg(CFG_MAX_OUT_FREQ, 30'd1000000000);
    send_request(32'd0, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'h0000_0000);
    drain_results();

    // A tiny output limit against a large reference lowers the multiplier to zero.
    write_reg(CFG_OSC_RATE, 30'h3FF_FFFF);
    write_reg(CFG_MAX_OUT_FREQ, 30'd1);
    send_request(32'd156000000, 32'hFFFF_FFFF);
    send_request(32'd10000000, 32'h0000_0000);
    drain_results();
    write_reg(CFG_MAX_OUT_FREQ, 30'd0);
    send_request(32'd50000000, 32'hFFFF_FFFF);
    drain_results();

    write_reg(CFG_OSC_RATE, 30'h3FFF_FFFF);
    write_reg(CFG_MAX_OUT_FREQ, 30'h3FFF_FFFF);
    write_reg(CFG_CLOCK_SOURCE, 30'd31);
    send_request(32'hFFFF_FFFF, 32'h0000_0000);
    send_request(32'd30000000, 32'hFFFF_FFFF);
    drain_results();
    write_reg(CFG_CLOCK_SOURCE, 30'h3FFF_FFE0);
    write_reg(CFG_UNUSED, 30'h3FFF_FFFF);
    send_request(32'd120000000, 32'hFFFF_FFFF);
    drain_results();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin osc = 26'd12000000; max_f = 30'd204000000; src = 5'd6; end
        1: begin osc = 26'd50000000; max_f = 30'd1000000000; src = 5'd31; end
        2: begin osc = 26'd3; max_f = 30'd1; src = 5'd0; end
        default: begin
          osc = ($urandom_range(0, 3) == 0) ? 26'($urandom_range(3, 3000))
                                            : 26'($urandom_range(3, 50000000));
          max_f = ($urandom_range(0, 1) == 0) ? 30'($urandom_range(1, 1000000000))
                                              : 30'($urandom_range(50000000, 300000000));
          src = 5'($urandom_range(0, 31));
        end
      endcase
      // Bits above a register's width are written too; they must be dropped.
      noise = ($urandom_range(0, 2) == 0) ? 30'($urandom) : '0;
      write_reg(CFG_OSC_RATE, {noise[29:26], osc});
      write_reg(CFG_MAX_OUT_FREQ, max_f);
      write_reg(CFG_CLOCK_SOURCE, {noise[29:5], src});
      set_idling(phase % 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 5))
          0: target = $urandom;
          1: target = $urandom_range(0, 20000000);
          2: target = $urandom_range(10000000, 200000000);
          3: target = (32'd156000000 >> $urandom_range(0, 4)) + $urandom_range(0, 4) - 2;
          4: target = $urandom_range(156000000, 32'hFFFF_FFFF);
          default: target = 32'(max_f >> $urandom_range(0, 4)) + $urandom_range(0, 8) - 4;
        endcase
        send_request(target, $urandom);
      end
      drain_results();
    end

    set_idling(0);
    repeat (100) @(negedge clk);
    if (board.pending_words.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               board.pending_words.size());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
